@@ hdl/mips_subset_alu_regfile_assert.svh @@
// assertion macros shared by the block's modules
`ifndef MIPS_SUBSET_ALU_REGFILE_ASSERT_SVH
`define MIPS_SUBSET_ALU_REGFILE_ASSERT_SVH

`ifndef SYNTHESIS
`define MSAR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define MSAR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define MSAR_ASSERT(lbl, clk, rst, prop)
`define MSAR_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif

`endif

@@ hdl/msar_pkg.sv @@
package msar_pkg;

   // instruction codes
   typedef enum logic [4:0] {
      ACT_ADD   = 5'd0,
      ACT_ADDU  = 5'd1,
      ACT_SUB   = 5'd2,
      ACT_SUBU  = 5'd3,
      ACT_ADDI  = 5'd4,
      ACT_ADDIU = 5'd5,
      ACT_MUL   = 5'd6,
      ACT_MULT  = 5'd7,
      ACT_DIV   = 5'd8,
      ACT_AND   = 5'd9,
      ACT_ANDI  = 5'd10,
      ACT_OR    = 5'd11,
      ACT_ORI   = 5'd12,
      ACT_XOR   = 5'd13,
      ACT_XORI  = 5'd14,
      ACT_SLL   = 5'd15,
      ACT_SRL   = 5'd16,
      ACT_LI    = 5'd17
   } action_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_INVALID  = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_OPER,
      S_EXEC,
      S_MUL,
      S_DIV,
      S_DIVFIX,
      S_FINISH
   } state_type;

   localparam int DATA_W   = 32;
   localparam int IDX_W    = 5;
   localparam int STEP_W   = 5;
   localparam int REQ_W    = 56;
   localparam int RSP_W    = 136;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic load_opnd;
      logic exec;
      logic mul_fix;
      logic div_step;
      logic div_fix;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_mul;
      logic is_div;
      logic div_zero;
      logic div_last;
      logic out_free;
   } sts_type;

endpackage

@@ hdl/mips_subset_alu_regfile.sv @@
// channel   dir  fields (low bit first)
// req_*     in   action, dest_reg, src_reg_a, src_reg_b, immediate
// rsp_*     out  wrote_reg, write_index, write_value, hi_value, lo_value,
//                executed_count, status
// one item in flight; each item passes operand fetch and execute, then for mul and mult
// a sign fix of the product, for div a 32-step shift-subtract and a sign fix; a div by a
// zero divisor skips the divide; a new request is taken only after the commit
// the result sits in an output register; a stalled rsp holds the next commit
// synchronous reset clears hi, lo, the counter and per-register valid bits;
// unwritten registers read as zero, no clearing pass
module mips_subset_alu_regfile #(
   parameter int NUM_REGS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action[4:0] dest_reg[9:5] src_reg_a[14:10] src_reg_b[19:15] immediate[51:20]
   input  logic [55:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // wrote_reg[0] write_index[5:1] write_value[37:6] hi_value[69:38]
   // lo_value[101:70] executed_count[133:102] status[135:134]
   output logic [135:0] rsp_tdata
);
   import msar_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer
   msar_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // register file, alu, multiplier, divider
   msar_dpath #(
      .NUM_REGS(NUM_REGS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ hdl/msar_ram.sv @@
module msar_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ hdl/msar_ctrl.sv @@
`include "mips_subset_alu_regfile_assert.svh"

module msar_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output msar_pkg::cmd_type cmd,
   input  msar_pkg::sts_type sts
);
   import msar_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_OPER;
            end
         end
         S_OPER: begin
            cmd.load_opnd = 1'b1;
            state_in      = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            priority if (sts.is_mul) begin
               state_in = S_MUL;
            end else if (sts.is_div && !sts.div_zero) begin
               state_in = S_DIV;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_MUL: begin
            cmd.mul_fix = 1'b1;
            state_in    = S_FINISH;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_DIVFIX;
            end
         end
         S_DIVFIX: begin
            cmd.div_fix = 1'b1;
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // an accepted item always moves on to the operand fetch
   `MSAR_ASSERT_IMPL(a_accept_oper, clock, reset, cmd.load_req, ##1 state_ff == S_OPER)
   // the last divide step hands over to the sign fix
   `MSAR_ASSERT_IMPL(a_div_end, clock, reset, cmd.div_step && sts.div_last,
                     ##1 state_ff == S_DIVFIX)
   // results are only committed into a free output register
   `MSAR_ASSERT_IMPL(a_commit_free, clock, reset, cmd.commit, sts.out_free)

endmodule

@@ hdl/msar_dpath.sv @@
`include "mips_subset_alu_regfile_assert.svh"

module msar_dpath #(
   parameter int NUM_REGS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  msar_pkg::cmd_type             cmd,
   output msar_pkg::sts_type             sts,
   input  logic [msar_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [msar_pkg::RSP_W-1:0]    rsp_tdata
);
   import msar_pkg::*;

   localparam int ADDR_W = $clog2(NUM_REGS);
   localparam logic [IDX_W+1:0] NUM_REGS_W = (IDX_W+2)'(NUM_REGS);

   // request fields
   logic [IDX_W-1:0]  req_action;
   logic [IDX_W-1:0]  req_dest;
   logic [IDX_W-1:0]  req_src_a;
   logic [IDX_W-1:0]  req_src_b;
   logic [DATA_W-1:0] req_imm;

   assign req_action = req_tdata[4:0];
   assign req_dest   = req_tdata[9:5];
   assign req_src_a  = req_tdata[14:10];
   assign req_src_b  = req_tdata[19:15];
   assign req_imm    = req_tdata[51:20];

   action_type         op_ff;
   logic [IDX_W-1:0]   rd_ff;
   logic [DATA_W-1:0]  imm_ff;
   logic               a_ok_ff, b_ok_ff;
   logic [DATA_W-1:0]  a_ff, b_ff;
   logic [NUM_REGS-1:0] valid_ff;
   logic [DATA_W-1:0]  hi_ff, lo_ff, cnt_ff;
   logic [DATA_W-1:0]  val_ff, hi_nxt_ff, lo_nxt_ff;
   logic               wr_ff;
   status_type         status_ff;
   logic [2*DATA_W-1:0] prod_ff;
   logic               neg_ff, sa_ff;
   logic [DATA_W-1:0]  rem_ff, quot_ff, dvs_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               rsp_valid_ff;
   logic [RSP_W-1:0]   rsp_data_ff;

   logic [ADDR_W-1:0]  addr_a, addr_b, addr_w;
   logic               a_in_rng, b_in_rng, d_in_rng;
   logic [DATA_W-1:0]  ram_a, ram_b;
   logic [DATA_W-1:0]  mag_a, mag_b, alu_val;
   logic               alu_wr, alu_bad;
   logic [2*DATA_W-1:0] prod_fix;
   logic [DATA_W:0]    div_trial, div_diff;
   logic [DATA_W-1:0]  quot_fix, rem_fix;

   assign addr_a   = ADDR_W'(req_src_a);
   assign addr_b   = ADDR_W'(req_src_b);
   assign addr_w   = ADDR_W'(rd_ff);
   assign a_in_rng = {2'b00, req_src_a} < NUM_REGS_W;
   assign b_in_rng = {2'b00, req_src_b} < NUM_REGS_W;
   assign d_in_rng = {2'b00, rd_ff} < NUM_REGS_W;

   msar_ram #(
      .WIDTH(DATA_W),
      .DEPTH(NUM_REGS)
   ) u_regs (
      .clock     (clock),
      .wr_en     (cmd.commit && wr_ff),
      .wr_addr   (addr_w),
      .wr_data   (val_ff),
      .rd_en     (cmd.load_req),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   // simple alu ops
   always_comb begin
      alu_val = '0;
      alu_wr  = 1'b1;
      alu_bad = 1'b0;
      unique case (op_ff)
         ACT_ADD, ACT_ADDU:   alu_val = a_ff + b_ff;
         ACT_SUB, ACT_SUBU:   alu_val = a_ff - b_ff;
         ACT_ADDI, ACT_ADDIU: alu_val = a_ff + imm_ff;
         ACT_AND:  alu_val = a_ff & b_ff;
         ACT_ANDI: alu_val = a_ff & imm_ff;
         ACT_OR:   alu_val = a_ff | b_ff;
         ACT_ORI:  alu_val = a_ff | imm_ff;
         ACT_XOR:  alu_val = a_ff ^ b_ff;
         ACT_XORI: alu_val = a_ff ^ imm_ff;
         ACT_SLL:  alu_val = a_ff << imm_ff[4:0];
         ACT_SRL:  alu_val = a_ff >> imm_ff[4:0];
         ACT_LI:   alu_val = imm_ff;
         ACT_MUL:  alu_val = '0;
         ACT_MULT, ACT_DIV: alu_wr = 1'b0;
         default: begin
            alu_wr  = 1'b0;
            alu_bad = 1'b1;
         end
      endcase
   end

   // operand magnitudes, product sign fix, divide step
   assign mag_a     = a_ff[DATA_W-1] ? DATA_W'(0) - a_ff : a_ff;
   assign mag_b     = b_ff[DATA_W-1] ? DATA_W'(0) - b_ff : b_ff;
   assign prod_fix  = neg_ff ? (2*DATA_W)'(0) - prod_ff : prod_ff;
   assign div_trial = {rem_ff, quot_ff[DATA_W-1]};
   assign div_diff  = div_trial - {1'b0, dvs_ff};
   assign quot_fix  = neg_ff ? DATA_W'(0) - quot_ff : quot_ff;
   assign rem_fix   = sa_ff ? DATA_W'(0) - rem_ff : rem_ff;

   // status to controller
   assign sts.is_mul   = (op_ff == ACT_MUL) || (op_ff == ACT_MULT);
   assign sts.is_div   = op_ff == ACT_DIV;
   assign sts.div_zero = b_ff == '0;
   assign sts.div_last = step_ff == '1;
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   // control state: valid bits, hi/lo, counter, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         hi_ff        <= '0;
         lo_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            if (wr_ff) begin
               valid_ff[addr_w] <= 1'b1;
            end
            hi_ff        <= hi_nxt_ff;
            lo_ff        <= lo_nxt_ff;
            cnt_ff       <= cnt_ff + DATA_W'(1);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item working registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= action_type'(req_action);
         rd_ff   <= req_dest;
         imm_ff  <= req_imm;
         a_ok_ff <= a_in_rng && valid_ff[addr_a];
         b_ok_ff <= b_in_rng && valid_ff[addr_b];
      end
      if (cmd.load_opnd) begin
         a_ff <= a_ok_ff ? ram_a : '0;
         b_ff <= b_ok_ff ? ram_b : '0;
      end
      if (cmd.exec) begin
         val_ff    <= alu_val;
         wr_ff     <= alu_wr && d_in_rng;
         status_ff <= alu_bad ? ST_INVALID :
                      (sts.is_div && sts.div_zero) ? ST_DIV_ZERO : ST_OK;
         hi_nxt_ff <= hi_ff;
         lo_nxt_ff <= lo_ff;
         prod_ff   <= mag_a * mag_b;
         neg_ff    <= a_ff[DATA_W-1] ^ b_ff[DATA_W-1];
         sa_ff     <= a_ff[DATA_W-1];
         rem_ff    <= '0;
         quot_ff   <= mag_a;
         dvs_ff    <= mag_b;
         step_ff   <= '0;
      end
      if (cmd.mul_fix) begin
         if (op_ff == ACT_MULT) begin
            hi_nxt_ff <= prod_fix[2*DATA_W-1:DATA_W];
            lo_nxt_ff <= prod_fix[DATA_W-1:0];
         end else begin
            val_ff <= prod_fix[DATA_W-1:0];
         end
      end
      if (cmd.div_step) begin
         step_ff <= step_ff + STEP_W'(1);
         if (div_diff[DATA_W]) begin
            rem_ff  <= div_trial[DATA_W-1:0];
            quot_ff <= {quot_ff[DATA_W-2:0], 1'b0};
         end else begin
            rem_ff  <= div_diff[DATA_W-1:0];
            quot_ff <= {quot_ff[DATA_W-2:0], 1'b1};
         end
      end
      if (cmd.div_fix) begin
         lo_nxt_ff <= quot_fix;
         hi_nxt_ff <= rem_fix;
      end
      if (cmd.commit) begin
         rsp_data_ff <= {status_ff, cnt_ff + DATA_W'(1), lo_nxt_ff, hi_nxt_ff,
                         wr_ff ? val_ff : DATA_W'(0),
                         wr_ff ? rd_ff : IDX_W'(0), wr_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a result shows up only after a commit
   `MSAR_ASSERT_IMPL(a_rsp_commit, clock, reset, $rose(rsp_valid_ff), $past(cmd.commit))
   // error items never write the register file
   `MSAR_ASSERT_IMPL(a_err_nowr, clock, reset, rsp_valid_ff && rsp_data_ff[135:134] != ST_OK,
                     !rsp_data_ff[0])
   // the counter moves by one per committed item
   `MSAR_ASSERT_IMPL(a_cnt_step, clock, reset, cmd.commit,
                     ##1 cnt_ff == $past(cnt_ff) + DATA_W'(1))

endmodule

@@ bench/tb_mips_subset_alu_regfile.sv @@
module tb_mips_subset_alu_regfile;
   import msar_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   // action, dest_reg, src_reg_a, src_reg_b, immediate
   logic [55:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   // wrote_reg, write_index, write_value, hi_value, lo_value, executed_count, status
   logic [135:0] rsp_tdata;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] executed_count;
      logic [31:0] lo_value;
      logic [31:0] hi_value;
      logic [31:0] write_value;
      logic [4:0]  write_index;
      logic        wrote_reg;
   } exec_result_t;

   typedef struct packed {
      logic [31:0] immediate;
      logic [4:0]  src_b;
      logic [4:0]  src_a;
      logic [4:0]  dest;
      logic [4:0]  action;
   } instr_t;

   // directed row: instruction plus optional typed-in result
   typedef struct {
      instr_t       instr;
      bit           typed;
      exec_result_t result;
   } row_t;

   mips_subset_alu_regfile DUT (.*);

   // shadow architectural state
   logic [31:0]  shadow_regs [32];
   logic [31:0]  shadow_hi, shadow_lo, shadow_count;
   exec_result_t pending_results [$];
   exec_result_t typed_results [$];
   bit           typed_flags [$];

   int  mismatch_count;
   int  send_idle_pct, recv_idle_pct;
   bit  recv_hold;
   int  recv_hold_cycles;
   row_t rows [$];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50000000;
      $display("status: fail");
      $finish;
   end

   // execute one instruction against the shadow state
   function automatic exec_result_t execute_instr(instr_t ins);
      exec_result_t r;
      logic [31:0] a, b, v, ma, mb, q, rm;
      logic [63:0] p;
      bit wr;
      a  = shadow_regs[ins.src_a];
      b  = shadow_regs[ins.src_b];
      v  = '0;
      wr = 1'b1;
      r  = '0;
      r.status = ST_OK;
      case (ins.action)
         ACT_ADD, ACT_ADDU:   v = a + b;
         ACT_SUB, ACT_SUBU:   v = a - b;
         ACT_ADDI, ACT_ADDIU: v = a + ins.immediate;
         ACT_MUL:  v = a * b;
         ACT_MULT: begin
            p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            shadow_hi = p[63:32];
            shadow_lo = p[31:0];
            wr = 1'b0;
         end
         ACT_DIV: begin
            wr = 1'b0;
            if (b == 0) begin
               r.status = ST_DIV_ZERO;
            end else begin
               ma = a[31] ? -a : a;
               mb = b[31] ? -b : b;
               q  = ma / mb;
               rm = ma % mb;
               shadow_lo = (a[31] != b[31]) ? -q : q;
               shadow_hi = a[31] ? -rm : rm;
            end
         end
         ACT_AND:  v = a & b;
         ACT_ANDI: v = a & ins.immediate;
         ACT_OR:   v = a | b;
         ACT_ORI:  v = a | ins.immediate;
         ACT_XOR:  v = a ^ b;
         ACT_XORI: v = a ^ ins.immediate;
         ACT_SLL:  v = a << ins.immediate[4:0];
         ACT_SRL:  v = a >> ins.immediate[4:0];
         ACT_LI:   v = ins.immediate;
         default: begin
            wr = 1'b0;
            r.status = ST_INVALID;
         end
      endcase
      if (wr) shadow_regs[ins.dest] = v;
      shadow_count++;
      r.wrote_reg      = wr;
      r.write_index    = wr ? ins.dest : '0;
      r.write_value    = wr ? v : '0;
      r.hi_value       = shadow_hi;
      r.lo_value       = shadow_lo;
      r.executed_count = shadow_count;
      return r;
   endfunction

   function automatic instr_t mk(logic [4:0] act, logic [4:0] d, logic [4:0] sa,
                                 logic [4:0] sb, logic [31:0] imm);
      instr_t i;
      i.action = act; i.dest = d; i.src_a = sa; i.src_b = sb; i.immediate = imm;
      return i;
   endfunction

   function automatic void add_row(instr_t i, bit typed, exec_result_t r);
      row_t x;
      x.instr = i; x.typed = typed; x.result = r;
      rows.push_back(x);
   endfunction

   function automatic exec_result_t mkres(bit w, logic [4:0] idx, logic [31:0] v,
                                          logic [31:0] h, logic [31:0] l,
                                          logic [31:0] c, logic [1:0] s);
      exec_result_t r;
      r.wrote_reg = w; r.write_index = idx; r.write_value = v; r.hi_value = h;
      r.lo_value = l; r.executed_count = c; r.status = s;
      return r;
   endfunction

   // random instruction, mostly valid with biased operands
   function automatic instr_t random_instr();
      instr_t i;
      i.action = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                                              : 5'($urandom_range(0, 17));
      i.dest  = 5'($urandom);
      i.src_a = 5'($urandom);
      i.src_b = 5'($urandom);
      case ($urandom_range(0, 5))
         0: i.immediate = 32'h8000_0000;
         1: i.immediate = 32'hFFFF_FFFF;
         2: i.immediate = 32'($urandom_range(0, 3));
         default: i.immediate = $urandom;
      endcase
      return i;
   endfunction

   task automatic send_item(instr_t ins, bit typed, exec_result_t r);
      // idle cycles with nothing offered
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= 56'(ins);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(execute_instr(ins));
      typed_flags.push_back(typed);
      typed_results.push_back(r);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
   endtask

   // receiver ready control
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // long receiver hold-off, counted here
   always @(negedge clock) begin
      if (recv_hold_cycles > 0) begin
         recv_hold_cycles <= recv_hold_cycles - 1;
         recv_hold <= (recv_hold_cycles > 1);
      end
   end

   // result checker
   always @(posedge clock) begin
      exec_result_t got, want, typed_r;
      bit typed;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected item %h", got);
         end else begin
            want    = pending_results.pop_front();
            typed   = typed_flags.pop_front();
            typed_r = typed_results.pop_front();
            if (typed && typed_r != want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("table row disagrees: table %h computed %h", typed_r, want);
            end
            if (got.wrote_reg != want.wrote_reg || got.write_index != want.write_index
                || got.write_value != want.write_value || got.hi_value != want.hi_value
                || got.lo_value != want.lo_value
                || got.executed_count != want.executed_count
                || got.status != want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %h actual %h", want, got);
            end
         end
      end
   end

   initial begin
      exec_result_t none;
      int n;
      none = '0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      recv_hold = 1'b0;
      recv_hold_cycles = 0;
      mismatch_count = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      foreach (shadow_regs[k]) shadow_regs[k] = '0;
      shadow_hi = '0; shadow_lo = '0; shadow_count = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      add_row(mk(ACT_ADD, 5'd1, 5'd0, 5'd0, 32'd0), 1, mkres(1, 1, 0, 0, 0, 1, ST_OK));
      add_row(mk(ACT_DIV, 5'd0, 5'd1, 5'd2, 32'd0), 1,
              mkres(0, 0, 0, 0, 0, 2, ST_DIV_ZERO));
      add_row(mk(5'd31, 5'd3, 5'd0, 5'd0, 32'd0), 1,
              mkres(0, 0, 0, 0, 0, 3, ST_INVALID));
      add_row(mk(ACT_LI, 5'd31, 5'd0, 5'd0, 32'h8000_0000), 1,
              mkres(1, 31, 32'h8000_0000, 0, 0, 4, ST_OK));
      add_row(mk(ACT_LI, 5'd30, 5'd0, 5'd0, 32'hFFFF_FFFF), 1,
              mkres(1, 30, 32'hFFFF_FFFF, 0, 0, 5, ST_OK));
      add_row(mk(ACT_LI, 5'd0, 5'd0, 5'd0, 32'h7FFF_FFFF), 1,
              mkres(1, 0, 32'h7FFF_FFFF, 0, 0, 6, ST_OK));
      add_row(mk(ACT_DIV, 5'd0, 5'd31, 5'd30, 32'd0), 1,
              mkres(0, 0, 0, 0, 32'h8000_0000, 7, ST_OK));
      add_row(mk(ACT_MULT, 5'd0, 5'd31, 5'd31, 32'd0), 0, none);
      add_row(mk(ACT_MULT, 5'd0, 5'd0, 5'd30, 32'd0), 0, none);
      add_row(mk(ACT_DIV, 5'd0, 5'd0, 5'd29, 32'd0), 0, none);
      add_row(mk(ACT_ADDU, 5'd2, 5'd0, 5'd0, 32'd0), 0, none);
      add_row(mk(ACT_SUB, 5'd3, 5'd31, 5'd0, 32'd0), 0, none);
      add_row(mk(ACT_SUBU, 5'd4, 5'd30, 5'd31, 32'd0), 0, none);
      add_row(mk(ACT_ADDI, 5'd5, 5'd0, 5'd0, 32'h8000_0001), 0, none);
      add_row(mk(ACT_ADDIU, 5'd6, 5'd30, 5'd0, 32'hFFFF_FFFF), 0, none);
      add_row(mk(ACT_MUL, 5'd7, 5'd0, 5'd30, 32'd0), 0, none);
      add_row(mk(ACT_AND, 5'd8, 5'd31, 5'd30, 32'd0), 0, none);
      add_row(mk(ACT_ANDI, 5'd9, 5'd30, 5'd0, 32'h0F0F_F0F0), 0, none);
      add_row(mk(ACT_OR, 5'd10, 5'd31, 5'd0, 32'd0), 0, none);
      add_row(mk(ACT_ORI, 5'd11, 5'd0, 5'd0, 32'hA5A5_5A5A), 0, none);
      add_row(mk(ACT_XOR, 5'd12, 5'd30, 5'd31, 32'd0), 0, none);
      add_row(mk(ACT_XORI, 5'd13, 5'd30, 5'd0, 32'hFFFF_FFFF), 0, none);
      add_row(mk(ACT_SLL, 5'd14, 5'd30, 5'd0, 32'hFFFF_FFFF), 0, none);
      add_row(mk(ACT_SRL, 5'd15, 5'd30, 5'd0, 32'h0000_0021), 0, none);
      add_row(mk(5'd18, 5'd16, 5'd30, 5'd31, 32'd0), 0, none);
      foreach (rows[k]) send_item(rows[k].instr, rows[k].typed, rows[k].result);
      wait_drained();

      // random traffic in three idling phases
      for (n = 0; n < 1200; n++) begin
         if (n == 0) begin
            send_idle_pct = 28; recv_idle_pct = 66;
         end else if (n == 400) begin
            send_idle_pct = 66; recv_idle_pct = 28;
         end else if (n == 800) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         // long receiver hold-off while items keep coming
         if (n == 200) recv_hold_cycles = 300;
         // sender waits until everything is back
         if (n == 600) wait_drained();
         send_item(random_instr(), 0, none);
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
